// ===== design/b2s_pkg.sv =====
// b2s_pkg: shared types, constants and the message schedule table
// for the BLAKE2s-256 hash core. Depends on nothing.
package b2s_pkg;

    localparam int unsigned BLOCK_WORDS = 16;
    localparam logic [6:0]  BLOCK_BYTES = 7'd64;

    localparam logic [31:0] IV [8] = '{
        32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
        32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19
    };

    // parameter block: digest length 32, fanout 1, depth 1, no key
    localparam logic [31:0] PARAM_WORD = 32'h01010000 ^ 32'd32;
    localparam logic [31:0] H0_INIT    = IV[0] ^ PARAM_WORD;

    localparam logic [3:0] SIGMA [10][16] = '{
        '{4'd0,  4'd1,  4'd2,  4'd3,  4'd4,  4'd5,  4'd6,  4'd7,
          4'd8,  4'd9,  4'd10, 4'd11, 4'd12, 4'd13, 4'd14, 4'd15},
        '{4'd14, 4'd10, 4'd4,  4'd8,  4'd9,  4'd15, 4'd13, 4'd6,
          4'd1,  4'd12, 4'd0,  4'd2,  4'd11, 4'd7,  4'd5,  4'd3},
        '{4'd11, 4'd8,  4'd12, 4'd0,  4'd5,  4'd2,  4'd15, 4'd13,
          4'd10, 4'd14, 4'd3,  4'd6,  4'd7,  4'd1,  4'd9,  4'd4},
        '{4'd7,  4'd9,  4'd3,  4'd1,  4'd13, 4'd12, 4'd11, 4'd14,
          4'd2,  4'd6,  4'd5,  4'd10, 4'd4,  4'd0,  4'd15, 4'd8},
        '{4'd9,  4'd0,  4'd5,  4'd7,  4'd2,  4'd4,  4'd10, 4'd15,
          4'd14, 4'd1,  4'd11, 4'd12, 4'd6,  4'd8,  4'd3,  4'd13},
        '{4'd2,  4'd12, 4'd6,  4'd10, 4'd0,  4'd11, 4'd8,  4'd3,
          4'd4,  4'd13, 4'd7,  4'd5,  4'd15, 4'd14, 4'd1,  4'd9},
        '{4'd12, 4'd5,  4'd1,  4'd15, 4'd14, 4'd13, 4'd4,  4'd10,
          4'd0,  4'd7,  4'd6,  4'd3,  4'd9,  4'd2,  4'd8,  4'd11},
        '{4'd13, 4'd11, 4'd7,  4'd14, 4'd12, 4'd1,  4'd3,  4'd9,
          4'd5,  4'd0,  4'd15, 4'd4,  4'd8,  4'd6,  4'd2,  4'd10},
        '{4'd6,  4'd15, 4'd14, 4'd9,  4'd11, 4'd3,  4'd0,  4'd8,
          4'd12, 4'd2,  4'd13, 4'd7,  4'd1,  4'd4,  4'd10, 4'd5},
        '{4'd10, 4'd2,  4'd8,  4'd4,  4'd7,  4'd6,  4'd1,  4'd5,
          4'd15, 4'd11, 4'd9,  4'd14, 4'd3,  4'd12, 4'd13, 4'd0}
    };

    function automatic logic [3:0] sigma_word(input logic [3:0] rnd, input logic [3:0] pos);
        logic [3:0] w;
        w = 4'd0;
        if (rnd < 4'd10) begin
            w = SIGMA[rnd][pos];
        end
        return w;
    endfunction

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_APPEND = 6'b000010,
        S_LOAD   = 6'b000100,
        S_ROUND  = 6'b001000,
        S_FINISH = 6'b010000,
        S_EMIT   = 6'b100000
    } t_state;

    typedef struct packed {
        logic       wr_en;
        logic [5:0] wr_addr;
        logic [7:0] wr_byte;
        logic       rd_en;
        logic [3:0] rd_word;
    } t_buf_ctl;

endpackage

// ===== design/b2s_ifs.sv =====
// b2s_in_if and b2s_out_if: valid/ready channels for message bytes in
// and digest words out. Depends on nothing.
interface b2s_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       has_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output has_byte, output last_byte,
                    input ready);
    modport sink   (input valid, input data_byte, input has_byte, input last_byte,
                    output ready);
endinterface

interface b2s_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;

    modport source (output valid, output digest_word, output word_index, output last_word,
                    input ready);
    modport sink   (input valid, input digest_word, input word_index, input last_word,
                    output ready);
endinterface

// ===== design/b2s_msg_buf.sv =====
// b2s_msg_buf: 16 x 32-bit block buffer, byte-lane writes, registered word
// reads with zero padding beyond the fill count. Depends on b2s_pkg.
module b2s_msg_buf (
    input  logic              i_clk,
    input  b2s_pkg::t_buf_ctl i_ctl,
    input  logic [6:0]        i_fill,
    output logic [31:0]       o_word
);

    logic [31:0] r_mem [b2s_pkg::BLOCK_WORDS];
    logic [31:0] r_rd;
    logic [3:0]  r_rd_idx;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_ctl.wr_addr[5:2]][8*i_ctl.wr_addr[1:0] +: 8] <= i_ctl.wr_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.rd_en) begin
            r_rd     <= r_mem[i_ctl.rd_word];
            r_rd_idx <= i_ctl.rd_word;
        end
    end

    // zero every byte at or beyond the fill count
    always_comb begin
        for (int j = 0; j < 4; j++) begin
            o_word[8*j +: 8] = ({1'b0, r_rd_idx, 2'(j)} < i_fill) ? r_rd[8*j +: 8] : 8'd0;
        end
    end

endmodule

// ===== design/b2s_g_half.sv =====
// b2s_g_half: one half of the BLAKE2s G mixing function on a single
// column (a, b, c, d) and one message word. Depends on nothing.
module b2s_g_half (
    input  logic [31:0] i_a,
    input  logic [31:0] i_b,
    input  logic [31:0] i_c,
    input  logic [31:0] i_d,
    input  logic [31:0] i_m,
    input  logic        i_second,
    output logic [31:0] o_a,
    output logic [31:0] o_b,
    output logic [31:0] o_c,
    output logic [31:0] o_d
);

    logic [31:0] dx;
    logic [31:0] bx;

    always_comb begin
        o_a = i_a + i_b + i_m;
        dx  = i_d ^ o_a;
        o_d = i_second ? {dx[7:0], dx[31:8]} : {dx[15:0], dx[31:16]};
        o_c = i_c + o_d;
        bx  = i_b ^ o_c;
        o_b = i_second ? {bx[6:0], bx[31:7]} : {bx[11:0], bx[31:12]};
    end

endmodule

// ===== design/blake2s_256_hash.sv =====
// Unkeyed BLAKE2s-256 core. Bytes enter one transaction at a time on i_byte; a transaction
// with last_byte set finishes the message and the eight digest words leave on o_digest,
// word 0 first, each word little-endian. A byte is accepted, then written into the buffer.
// Compressing a block takes a load step, then one shared half-G unit works through 10
// rounds x 8 G calls x 2 halves on a rotating work vector, then a feed-forward step.
// A full block is compressed when the next byte arrives; no byte is accepted meanwhile.
// No input is taken from the last transaction until the last digest word is taken.
// Depends on b2s_pkg, b2s_ifs, b2s_msg_buf and b2s_g_half.
module blake2s_256_hash (
    input  logic       i_clk,
    input  logic       i_rst_n,
    b2s_in_if.sink     i_byte,
    b2s_out_if.source  o_digest
);

    b2s_pkg::t_state   r_state;
    b2s_pkg::t_state   n_state;
    b2s_pkg::t_buf_ctl buf_ctl;

    logic [31:0] r_h [8];
    logic [63:0] r_count;
    logic [6:0]  r_fill;
    logic [31:0] r_v [16];
    logic [31:0] n_v [16];
    logic [31:0] vt  [16];
    logic [1:0]  amt [4];
    logic [3:0]  r_round;
    logic [2:0]  r_g;
    logic        r_half;
    logic        r_final;
    logic [7:0]  r_byte;
    logic        r_has;
    logic        r_last;
    logic [2:0]  r_widx;

    logic        in_acc;
    logic        out_acc;
    logic        full;
    logic        last_step;
    logic [6:0]  fill_app;
    logic        nx_half;
    logic [2:0]  nx_g;
    logic [3:0]  nx_round;
    logic [31:0] msg_word;
    logic [31:0] ga;
    logic [31:0] gb;
    logic [31:0] gc;
    logic [31:0] gd;

    assign in_acc    = i_byte.valid && i_byte.ready;
    assign out_acc   = o_digest.valid && o_digest.ready;
    assign full      = (r_fill == b2s_pkg::BLOCK_BYTES);
    assign fill_app  = r_fill + {6'd0, r_has};
    assign last_step = (r_round == 4'd9) && (r_g == 3'd7) && r_half;
    assign nx_half   = ~r_half;
    assign nx_g      = r_g + {2'd0, r_half};
    assign nx_round  = r_round + {3'd0, (r_half && (r_g == 3'd7))};

    assign i_byte.ready         = (r_state == b2s_pkg::S_IDLE);
    assign o_digest.valid       = (r_state == b2s_pkg::S_EMIT);
    assign o_digest.digest_word = r_h[r_widx];
    assign o_digest.word_index  = r_widx;
    assign o_digest.last_word   = (r_widx == 3'd7);

    always_comb begin
        buf_ctl.wr_en   = (r_state == b2s_pkg::S_APPEND) && r_has;
        buf_ctl.wr_addr = r_fill[5:0];
        buf_ctl.wr_byte = r_byte;
        buf_ctl.rd_en   = (r_state == b2s_pkg::S_LOAD) || (r_state == b2s_pkg::S_ROUND);
        buf_ctl.rd_word = (r_state == b2s_pkg::S_LOAD) ? b2s_pkg::sigma_word(4'd0, 4'd0)
                        : b2s_pkg::sigma_word(nx_round, {nx_g, nx_half});
    end

    b2s_msg_buf u_buf (
        .i_clk  (i_clk),
        .i_ctl  (buf_ctl),
        .i_fill (r_fill),
        .o_word (msg_word)
    );

    b2s_g_half u_g (
        .i_a      (r_v[0]),
        .i_b      (r_v[4]),
        .i_c      (r_v[8]),
        .i_d      (r_v[12]),
        .i_m      (msg_word),
        .i_second (r_half),
        .o_a      (ga),
        .o_b      (gb),
        .o_c      (gc),
        .o_d      (gd)
    );

    // rotate rows left after each G; diagonalise after column 3, undo after diagonal 3
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            amt[k] = 2'd1 + ((r_g == 3'd3) ? 2'(k) : (r_g == 3'd7) ? 2'(4 - k) : 2'd0);
        end
        vt     = r_v;
        vt[0]  = ga;
        vt[4]  = gb;
        vt[8]  = gc;
        vt[12] = gd;
        n_v    = r_v;
        case (r_state)
            b2s_pkg::S_LOAD: begin
                for (int i = 0; i < 8; i++) begin
                    n_v[i]     = r_h[i];
                    n_v[i + 8] = b2s_pkg::IV[i];
                end
                n_v[12] = b2s_pkg::IV[4] ^ r_count[31:0];
                n_v[13] = b2s_pkg::IV[5] ^ r_count[63:32];
                n_v[14] = b2s_pkg::IV[6] ^ {32{r_final}};
            end
            b2s_pkg::S_ROUND: begin
                if (!r_half) begin
                    n_v = vt;
                end else begin
                    for (int row = 0; row < 4; row++) begin
                        for (int col = 0; col < 4; col++) begin
                            n_v[4*row + col] = vt[{2'(row), 2'(2'(col) + amt[row])}];
                        end
                    end
                end
            end
            default: begin
                n_v = r_v;
            end
        endcase
    end

    always_comb begin
        case (r_state)
            b2s_pkg::S_IDLE: begin
                if (in_acc) begin
                    n_state = (i_byte.has_byte && full) ? b2s_pkg::S_LOAD : b2s_pkg::S_APPEND;
                end else begin
                    n_state = b2s_pkg::S_IDLE;
                end
            end
            b2s_pkg::S_APPEND: n_state = r_last ? b2s_pkg::S_LOAD : b2s_pkg::S_IDLE;
            b2s_pkg::S_LOAD:   n_state = b2s_pkg::S_ROUND;
            b2s_pkg::S_ROUND:  n_state = last_step ? b2s_pkg::S_FINISH : b2s_pkg::S_ROUND;
            b2s_pkg::S_FINISH: n_state = r_final ? b2s_pkg::S_EMIT : b2s_pkg::S_APPEND;
            b2s_pkg::S_EMIT: begin
                n_state = (out_acc && (r_widx == 3'd7)) ? b2s_pkg::S_IDLE : b2s_pkg::S_EMIT;
            end
            default:           n_state = b2s_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_v <= n_v;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= b2s_pkg::S_IDLE;
            r_h[0]  <= b2s_pkg::H0_INIT;
            for (int i = 1; i < 8; i++) begin
                r_h[i] <= b2s_pkg::IV[i];
            end
            r_count <= 64'd0;
            r_fill  <= 7'd0;
            r_widx  <= 3'd0;
            r_final <= 1'b0;
            r_round <= 4'd0;
            r_g     <= 3'd0;
            r_half  <= 1'b0;
            r_has   <= 1'b0;
            r_last  <= 1'b0;
        end else begin
            r_state <= n_state;
            case (r_state)
                b2s_pkg::S_IDLE: begin
                    if (in_acc) begin
                        r_byte <= i_byte.data_byte;
                        r_has  <= i_byte.has_byte;
                        r_last <= i_byte.last_byte;
                        if (i_byte.has_byte && full) begin
                            r_count <= r_count + 64'd64;
                            r_final <= 1'b0;
                        end
                    end
                end
                b2s_pkg::S_APPEND: begin
                    r_fill <= fill_app;
                    if (r_last) begin
                        r_count <= r_count + {57'd0, fill_app};
                        r_final <= 1'b1;
                    end
                end
                b2s_pkg::S_LOAD: begin
                    r_round <= 4'd0;
                    r_g     <= 3'd0;
                    r_half  <= 1'b0;
                end
                b2s_pkg::S_ROUND: begin
                    r_round <= nx_round;
                    r_g     <= nx_g;
                    r_half  <= nx_half;
                end
                b2s_pkg::S_FINISH: begin
                    for (int i = 0; i < 8; i++) begin
                        r_h[i] <= r_h[i] ^ r_v[i] ^ r_v[i + 8];
                    end
                    if (!r_final) begin
                        r_fill <= 7'd0;
                    end
                end
                b2s_pkg::S_EMIT: begin
                    if (out_acc) begin
                        r_widx <= r_widx + 3'd1;
                        if (r_widx == 3'd7) begin
                            r_h[0] <= b2s_pkg::H0_INIT;
                            for (int i = 1; i < 8; i++) begin
                                r_h[i] <= b2s_pkg::IV[i];
                            end
                            r_count <= 64'd0;
                            r_fill  <= 7'd0;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_byte.ready && o_digest.valid))
        else $error("input ready while digest pending");

    a_fill_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= b2s_pkg::BLOCK_BYTES)
        else $error("fill count beyond block size");

    a_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_acc && o_digest.last_word) |=> (r_fill == 7'd0 && r_count == 64'd0))
        else $error("message state not cleared after digest");

    a_index_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_acc && !o_digest.last_word) |=> (o_digest.valid
            && o_digest.word_index == $past(o_digest.word_index) + 3'd1))
        else $error("digest words out of order");

endmodule
